@@ rtl/qubit_state_vector_gate_engine_top_assert.svh @@
// assertion macros for the qubit state vector gate engine top level
// expects signals clk and rst_n in the including scope
`ifndef QUBIT_STATE_VECTOR_GATE_ENGINE_TOP_ASSERT_SVH
`define QUBIT_STATE_VECTOR_GATE_ENGINE_TOP_ASSERT_SVH

// same-cycle implication
`define QSV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QSV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/qsv_pkg.sv @@
// shared types and constants of the qubit state vector gate engine
// no dependencies
package qsv_pkg;

  localparam int DEF_MAX_QUBITS = 10;
  localparam int DEF_FRAC_BITS  = 16;
  localparam int MUL_YW         = 32;
  localparam logic signed [MUL_YW-1:0] INV_SQRT2_Q31 = 32'sd1518500250;
  localparam logic [3:0] NQ_RESET = 4'd10;

  typedef enum logic [3:0] {
    MODE_WRITE  = 4'd0,
    MODE_READ   = 4'd1,
    MODE_BASIS  = 4'd2,
    MODE_H      = 4'd3,
    MODE_X      = 4'd4,
    MODE_Y      = 4'd5,
    MODE_Z      = 4'd6,
    MODE_S      = 4'd7,
    MODE_CNOT   = 4'd8,
    MODE_CPHASE = 4'd9,
    MODE_FLIP   = 4'd10,
    MODE_DIFF   = 4'd11
  } qsv_mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_QUBIT = 2'd1,
    ST_BAD_INDEX = 2'd2
  } qsv_status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_WR, S_ADR, S_ONE, S_FILL, S_SUM, S_MEAN, S_SUB,
    S_PRD, S_PRK, S_PCMP, S_PMUL, S_PWRP, S_PWRK, S_DONE
  } qsv_state_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic first;
    logic sub;
    logic wide_shift;
  } qsv_mac_ctl_t;

endpackage

@@ rtl/qsv_if.sv @@
// valid/ready channel interfaces of the qubit state vector gate engine
// depends on qsv_pkg
interface qsv_in_if #(
  parameter int IW = qsv_pkg::DEF_MAX_QUBITS,
  parameter int VW = qsv_pkg::DEF_FRAC_BITS + 2
) ();
  logic                 valid;
  logic                 ready;
  logic [3:0]           mode;
  logic [3:0]           first_qubit;
  logic [3:0]           second_qubit;
  logic [IW-1:0]        index;
  logic signed [VW-1:0] value_re;
  logic signed [VW-1:0] value_im;
  modport source(output valid, mode, first_qubit, second_qubit, index, value_re, value_im,
                 input ready);
  modport sink(input valid, mode, first_qubit, second_qubit, index, value_re, value_im,
               output ready);
endinterface

interface qsv_out_if #(
  parameter int VW = qsv_pkg::DEF_FRAC_BITS + 2
) ();
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] amp_re;
  logic signed [VW-1:0] amp_im;
  logic [1:0]           status;
  modport source(output valid, amp_re, amp_im, status, input ready);
  modport sink(input valid, amp_re, amp_im, status, output ready);
endinterface

interface qsv_cfg_if ();
  logic       valid;
  logic       ready;
  logic [3:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

@@ rtl/qsv_mem.sv @@
// amplitude store: one write port, one read port with registered read data
// depends on qsv_pkg for default widths
module qsv_mem #(
  parameter int AW = qsv_pkg::DEF_MAX_QUBITS,
  parameter int DW = 2 * (qsv_pkg::DEF_FRAC_BITS + 2)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

@@ rtl/qsv_mac.sv @@
// shared multiply-accumulate unit with round-half-away and saturation
// depends on qsv_pkg
module qsv_mac #(
  parameter int FRAC_BITS = qsv_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  qsv_pkg::qsv_mac_ctl_t          ctl,
  input  logic signed [FRAC_BITS+2:0]    x,
  input  logic signed [qsv_pkg::MUL_YW-1:0] y,
  output logic signed [FRAC_BITS+1:0]    res
);
  localparam int VW = FRAC_BITS + 2;
  localparam int PW = VW + 1 + qsv_pkg::MUL_YW;
  localparam int AC = PW + 1;
  localparam logic [AC-1:0] HALF_W = AC'(1) << 30;
  localparam logic [AC-1:0] HALF_F = AC'(1) << (FRAC_BITS - 1);
  localparam logic signed [AC-1:0] SAT_MAX = AC'((64'(1) << (VW - 1)) - 64'(1));
  localparam logic signed [AC-1:0] SAT_MIN = -(AC'(64'(1) << (VW - 1)));

  logic signed [PW-1:0] prod_r;
  logic signed [AC-1:0] acc_r, acc_nxt, base, rnd;
  logic [AC-1:0]        mag, shifted;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= x * y;
    end
    if (ctl.acc_en) begin
      acc_r <= acc_nxt;
    end
  end

  always_comb begin
    base    = ctl.first ? '0 : acc_r;
    acc_nxt = ctl.sub ? base - AC'(prod_r) : base + AC'(prod_r);
    mag     = acc_nxt[AC-1] ? AC'(0) - acc_nxt : acc_nxt;
    shifted = ctl.wide_shift ? (mag + HALF_W) >> 31 : (mag + HALF_F) >> FRAC_BITS;
    rnd     = acc_nxt[AC-1] ? AC'(0) - shifted : shifted;
    if (rnd > SAT_MAX) begin
      res = SAT_MAX[VW-1:0];
    end else if (rnd < SAT_MIN) begin
      res = SAT_MIN[VW-1:0];
    end else begin
      res = rnd[VW-1:0];
    end
  end
endmodule

@@ rtl/qubit_state_vector_gate_engine_top.sv @@
// Qubit state vector gate engine. Holds 2^n complex Q1.16 amplitudes in a
// single-port-read, single-port-write memory and runs one transaction at a
// time under a sequencer. With L = 2^n, diffusion makes one summing sweep
// over the vector, then one update sweep. X, Y, Z, S, Hadamard, CNOT and
// controlled phase work on the L/2 amplitude pairs; Hadamard and
// controlled phase use the one shared multiplier, the others do not. CNOT
// and controlled phase skip pairs whose control bit is clear, and the
// pair sweeps share the one memory read port. An error status leaves
// the vector unchanged.
// A finished result waits in an output register; the next transaction is
// taken as soon as the sequencer is idle. Stored amplitudes are undefined
// until written, and num_qubits may be written only while idle.
`include "qubit_state_vector_gate_engine_top_assert.svh"

module qubit_state_vector_gate_engine_top #(
  parameter int MAX_QUBITS = qsv_pkg::DEF_MAX_QUBITS,
  parameter int FRAC_BITS  = qsv_pkg::DEF_FRAC_BITS
) (
  input logic         clk,
  input logic         rst_n,
  qsv_in_if.sink      in_if,
  qsv_out_if.source   out_if,
  qsv_cfg_if.sink     cfg_if
);
  localparam int VW = FRAC_BITS + 2;
  localparam int AW = MAX_QUBITS;
  localparam int DW = 2 * VW;
  localparam int SW = VW + MAX_QUBITS;
  localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic [VW-1:0] ONE_VAL = VW'(1) << FRAC_BITS;

  // saturating negate, most negative maps to most positive
  function automatic logic signed [VW-1:0] neg_sat(input logic signed [VW-1:0] v);
    if (v == VAL_MIN) begin
      return VAL_MAX;
    end
    return -v;
  endfunction

  // round half away from zero on a right shift
  function automatic logic signed [SW-1:0] round_shift(input logic signed [SW-1:0] v,
                                                       input logic [3:0] s);
    logic [SW:0] mag, half, r;
    mag  = v[SW-1] ? ((SW+1)'(0) - {v[SW-1], v}) : {1'b0, v};
    half = (s == 4'd0) ? '0 : ((SW+1)'(1) << (s - 4'd1));
    r    = (mag + half) >> s;
    return v[SW-1] ? SW'((SW+1)'(0) - r) : SW'(r);
  endfunction

  qsv_pkg::qsv_state_t state_r, state_nxt;

  // config register and derived vector length
  logic [3:0]  nq_r, nq_cl;
  logic [AW:0] len;

  // captured transaction
  logic [3:0]           mode_r, q1_r, q2_r;
  logic [AW-1:0]        idx_r;
  logic signed [VW-1:0] vr_r, vi_r;
  qsv_pkg::qsv_status_t status_r, st_in;

  // sequencer counters
  logic [AW:0] cnt_r;
  logic [2:0]  step_r;

  // pair operands and results
  logic signed [VW-1:0] a_r, b_r, c_r, d_r;
  logic signed [VW-1:0] np_re_r, np_im_r, nk_re_r, nk_im_r;
  logic signed [VW-1:0] rres_re_r, rres_im_r;

  // diffusion sums and mean
  logic signed [SW-1:0] sum_re_r, sum_im_r, mean_re_r, mean_im_r;
  logic signed [SW:0]   dif_re, dif_im;
  logic signed [VW-1:0] dsat_re, dsat_im;

  // output register
  logic                 out_valid_r;
  logic signed [VW-1:0] out_re_r, out_im_r;
  logic [1:0]           out_st_r;

  // memory port
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata, mem_rdata;
  logic signed [VW-1:0] rd_re, rd_im;

  // shared multiplier
  qsv_pkg::qsv_mac_ctl_t mac_ctl;
  logic signed [VW:0]    mac_x;
  logic signed [qsv_pkg::MUL_YW-1:0] mac_y;
  logic signed [VW-1:0]  mac_res;

  // decode helpers
  logic accept, slot_free, is_h, is_mul, two_q_r, pair_last, k_ctl;
  logic one_q_in, two_q_in, idx_in;
  logic [3:0]    tpos;
  logic [AW:0]   jx, low_mask, kx;
  logic [AW-1:0] k_addr, p_addr;
  logic [1:0]    mop, aop;
  logic signed [VW-1:0] cp_re, cp_im;

  assign rd_re = mem_rdata[DW-1:VW];
  assign rd_im = mem_rdata[VW-1:0];

  // ---- configuration: always ready; the user must write it only while idle, the block does not enforce this
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nq_r <= qsv_pkg::NQ_RESET;
    end else if (cfg_if.valid) begin
      nq_r <= cfg_if.data;
    end
  end

  // clamp to 1..MAX_QUBITS
  always_comb begin
    if (nq_r == 4'd0) begin
      nq_cl = 4'd1;
    end else if (32'(nq_r) > MAX_QUBITS) begin
      nq_cl = 4'(MAX_QUBITS);
    end else begin
      nq_cl = nq_r;
    end
  end
  assign len = (AW+1)'(1) << nq_cl;

  // ---- input checks
  assign accept = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == qsv_pkg::S_IDLE);

  always_comb begin
    one_q_in = in_if.mode inside {[qsv_pkg::MODE_H : qsv_pkg::MODE_S]};
    two_q_in = in_if.mode inside {qsv_pkg::MODE_CNOT, qsv_pkg::MODE_CPHASE};
    idx_in   = in_if.mode inside {[qsv_pkg::MODE_WRITE : qsv_pkg::MODE_BASIS],
                                  qsv_pkg::MODE_FLIP};
    if ((one_q_in || two_q_in) && in_if.first_qubit >= nq_cl) begin
      st_in = qsv_pkg::ST_BAD_QUBIT;
    end else if (two_q_in && (in_if.second_qubit >= nq_cl ||
                              in_if.second_qubit == in_if.first_qubit)) begin
      st_in = qsv_pkg::ST_BAD_QUBIT;
    end else if (idx_in && {1'b0, in_if.index} >= len) begin
      st_in = qsv_pkg::ST_BAD_INDEX;
    end else begin
      st_in = qsv_pkg::ST_OK;
    end
  end

  // ---- pair addressing: insert the target bit into the pair counter
  assign is_h    = (mode_r == qsv_pkg::MODE_H);
  assign two_q_r = (mode_r == qsv_pkg::MODE_CNOT) || (mode_r == qsv_pkg::MODE_CPHASE);
  assign is_mul  = is_h || (mode_r == qsv_pkg::MODE_CPHASE);
  assign tpos    = two_q_r ? q2_r : q1_r;
  assign jx       = {1'b0, cnt_r[AW-1:0]};
  assign low_mask = ((AW+1)'(1) << tpos) - (AW+1)'(1);
  assign kx       = ((jx >> tpos) << (5'(tpos) + 5'd1)) | ((AW+1)'(1) << tpos)
                    | (jx & low_mask);
  assign k_addr   = kx[AW-1:0];
  assign p_addr   = k_addr ^ (AW'(1) << tpos);
  assign k_ctl    = |(k_addr & (AW'(1) << q1_r));
  assign pair_last = (jx == ((len >> 1) - (AW+1)'(1)));

  // ---- non-multiplying pair results, c and d straight from the read port
  always_comb begin
    cp_re = a_r;
    cp_im = b_r;
    case (mode_r)
      qsv_pkg::MODE_X, qsv_pkg::MODE_CNOT: begin
        cp_re = rd_re;
        cp_im = rd_im;
      end
      qsv_pkg::MODE_Y: begin
        cp_re = rd_im;
        cp_im = neg_sat(rd_re);
      end
      default: begin
        cp_re = a_r;
        cp_im = b_r;
      end
    endcase
  end

  // ---- shared multiplier operands by step
  assign mop = step_r[1:0];
  assign aop = 2'(step_r - 3'd1);
  always_comb begin
    if (is_h) begin
      mac_y = qsv_pkg::INV_SQRT2_Q31;
      case (mop)
        2'd0:    mac_x = (VW+1)'(a_r) + (VW+1)'(c_r);
        2'd1:    mac_x = (VW+1)'(b_r) + (VW+1)'(d_r);
        2'd2:    mac_x = (VW+1)'(a_r) - (VW+1)'(c_r);
        default: mac_x = (VW+1)'(b_r) - (VW+1)'(d_r);
      endcase
    end else begin
      mac_x = mop[0] ? (VW+1)'(d_r) : (VW+1)'(c_r);
      mac_y = (mop == 2'd0 || mop == 2'd3) ? qsv_pkg::MUL_YW'(vr_r)
                                           : qsv_pkg::MUL_YW'(vi_r);
    end
  end

  // ---- diffusion update value
  assign dif_re = {mean_re_r[SW-1], mean_re_r} - (SW+1)'(rd_re);
  assign dif_im = {mean_im_r[SW-1], mean_im_r} - (SW+1)'(rd_im);
  assign dsat_re = (dif_re > (SW+1)'(VAL_MAX)) ? VAL_MAX :
                   (dif_re < (SW+1)'(VAL_MIN)) ? VAL_MIN : dif_re[VW-1:0];
  assign dsat_im = (dif_im > (SW+1)'(VAL_MAX)) ? VAL_MAX :
                   (dif_im < (SW+1)'(VAL_MIN)) ? VAL_MIN : dif_im[VW-1:0];

  assign slot_free = !out_valid_r || out_if.ready;

  // ---- sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qsv_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---- next state, memory port and multiplier control
  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = {vr_r, vi_r};
    mem_raddr = idx_r;
    mac_ctl   = '0;
    case (state_r)
      qsv_pkg::S_IDLE: begin
        if (accept) begin
          if (st_in != qsv_pkg::ST_OK || in_if.mode > qsv_pkg::MODE_DIFF) begin
            state_nxt = qsv_pkg::S_DONE;
          end else begin
            case (in_if.mode)
              qsv_pkg::MODE_WRITE: state_nxt = qsv_pkg::S_WR;
              qsv_pkg::MODE_READ,
              qsv_pkg::MODE_FLIP:  state_nxt = qsv_pkg::S_ADR;
              qsv_pkg::MODE_BASIS: state_nxt = qsv_pkg::S_FILL;
              qsv_pkg::MODE_DIFF:  state_nxt = qsv_pkg::S_SUM;
              default:             state_nxt = qsv_pkg::S_PRD;
            endcase
          end
        end
      end
      qsv_pkg::S_WR: begin
        mem_we    = 1'b1;
        state_nxt = qsv_pkg::S_DONE;
      end
      qsv_pkg::S_ADR: begin
        state_nxt = qsv_pkg::S_ONE;
      end
      qsv_pkg::S_ONE: begin
        // flip writes back the negated entry, read only captures it
        mem_we    = (mode_r == qsv_pkg::MODE_FLIP);
        mem_wdata = {neg_sat(rd_re), neg_sat(rd_im)};
        state_nxt = qsv_pkg::S_DONE;
      end
      qsv_pkg::S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[AW-1:0];
        mem_wdata = (cnt_r[AW-1:0] == idx_r) ? {ONE_VAL, VW'(0)} : '0;
        if (cnt_r == len - (AW+1)'(1)) begin
          state_nxt = qsv_pkg::S_DONE;
        end
      end
      qsv_pkg::S_SUM: begin
        mem_raddr = cnt_r[AW-1:0];
        if (cnt_r == len) begin
          state_nxt = qsv_pkg::S_MEAN;
        end
      end
      qsv_pkg::S_MEAN: begin
        state_nxt = qsv_pkg::S_SUB;
      end
      qsv_pkg::S_SUB: begin
        // read one ahead, write the entry read in the previous cycle
        mem_raddr = cnt_r[AW-1:0];
        mem_we    = (cnt_r != '0);
        mem_waddr = cnt_r[AW-1:0] - AW'(1);
        mem_wdata = {dsat_re, dsat_im};
        if (cnt_r == len) begin
          state_nxt = qsv_pkg::S_DONE;
        end
      end
      qsv_pkg::S_PRD: begin
        mem_raddr = p_addr;
        if (two_q_r && !k_ctl) begin
          state_nxt = pair_last ? qsv_pkg::S_DONE : qsv_pkg::S_PRD;
        end else begin
          state_nxt = qsv_pkg::S_PRK;
        end
      end
      qsv_pkg::S_PRK: begin
        mem_raddr = k_addr;
        state_nxt = qsv_pkg::S_PCMP;
      end
      qsv_pkg::S_PCMP: begin
        state_nxt = is_mul ? qsv_pkg::S_PMUL : qsv_pkg::S_PWRP;
      end
      qsv_pkg::S_PMUL: begin
        mac_ctl.mul_en     = (step_r != 3'd4);
        mac_ctl.acc_en     = (step_r != 3'd0);
        mac_ctl.first      = is_h || !aop[0];
        mac_ctl.sub        = !is_h && (aop == 2'd1);
        mac_ctl.wide_shift = is_h;
        if (step_r == 3'd4) begin
          state_nxt = qsv_pkg::S_PWRP;
        end
      end
      qsv_pkg::S_PWRP: begin
        mem_we    = 1'b1;
        mem_waddr = p_addr;
        mem_wdata = {np_re_r, np_im_r};
        state_nxt = qsv_pkg::S_PWRK;
      end
      qsv_pkg::S_PWRK: begin
        mem_we    = 1'b1;
        mem_waddr = k_addr;
        mem_wdata = {nk_re_r, nk_im_r};
        state_nxt = pair_last ? qsv_pkg::S_DONE : qsv_pkg::S_PRD;
      end
      qsv_pkg::S_DONE: begin
        if (slot_free) begin
          state_nxt = qsv_pkg::S_IDLE;
        end
      end
      default: state_nxt = qsv_pkg::S_IDLE;
    endcase
  end

  // ---- counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      step_r <= '0;
    end else begin
      case (state_r)
        qsv_pkg::S_IDLE: begin
          cnt_r  <= '0;
          step_r <= '0;
        end
        qsv_pkg::S_FILL, qsv_pkg::S_SUM, qsv_pkg::S_SUB: begin
          cnt_r <= cnt_r + (AW+1)'(1);
        end
        qsv_pkg::S_MEAN: begin
          cnt_r <= '0;
        end
        qsv_pkg::S_PRD: begin
          if (two_q_r && !k_ctl) begin
            cnt_r <= cnt_r + (AW+1)'(1);
          end
        end
        qsv_pkg::S_PCMP: begin
          step_r <= '0;
        end
        qsv_pkg::S_PMUL: begin
          step_r <= step_r + 3'd1;
        end
        qsv_pkg::S_PWRK: begin
          cnt_r <= cnt_r + (AW+1)'(1);
        end
        default: begin
          cnt_r  <= cnt_r;
          step_r <= step_r;
        end
      endcase
    end
  end

  // ---- datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      qsv_pkg::S_IDLE: begin
        if (accept) begin
          mode_r    <= in_if.mode;
          q1_r      <= in_if.first_qubit;
          q2_r      <= in_if.second_qubit;
          idx_r     <= in_if.index;
          vr_r      <= in_if.value_re;
          vi_r      <= in_if.value_im;
          status_r  <= st_in;
          rres_re_r <= '0;
          rres_im_r <= '0;
          sum_re_r  <= '0;
          sum_im_r  <= '0;
        end
      end
      qsv_pkg::S_ONE: begin
        if (mode_r == qsv_pkg::MODE_READ) begin
          rres_re_r <= rd_re;
          rres_im_r <= rd_im;
        end
      end
      qsv_pkg::S_SUM: begin
        if (cnt_r != '0) begin
          sum_re_r <= sum_re_r + SW'(rd_re);
          sum_im_r <= sum_im_r + SW'(rd_im);
        end
      end
      qsv_pkg::S_MEAN: begin
        mean_re_r <= round_shift(sum_re_r, nq_cl - 4'd1);
        mean_im_r <= round_shift(sum_im_r, nq_cl - 4'd1);
      end
      qsv_pkg::S_PRK: begin
        a_r <= rd_re;
        b_r <= rd_im;
      end
      qsv_pkg::S_PCMP: begin
        c_r     <= rd_re;
        d_r     <= rd_im;
        np_re_r <= cp_re;
        np_im_r <= cp_im;
        case (mode_r)
          qsv_pkg::MODE_X, qsv_pkg::MODE_CNOT: begin
            nk_re_r <= a_r;
            nk_im_r <= b_r;
          end
          qsv_pkg::MODE_Y: begin
            nk_re_r <= neg_sat(b_r);
            nk_im_r <= a_r;
          end
          qsv_pkg::MODE_Z: begin
            nk_re_r <= neg_sat(rd_re);
            nk_im_r <= neg_sat(rd_im);
          end
          qsv_pkg::MODE_S: begin
            nk_re_r <= neg_sat(rd_im);
            nk_im_r <= rd_re;
          end
          default: begin
            nk_re_r <= rd_re;
            nk_im_r <= rd_im;
          end
        endcase
      end
      qsv_pkg::S_PMUL: begin
        if (step_r != 3'd0) begin
          if (is_h) begin
            case (aop)
              2'd0:    np_re_r <= mac_res;
              2'd1:    np_im_r <= mac_res;
              2'd2:    nk_re_r <= mac_res;
              default: nk_im_r <= mac_res;
            endcase
          end else if (aop == 2'd1) begin
            nk_re_r <= mac_res;
          end else if (aop == 2'd3) begin
            nk_im_r <= mac_res;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // ---- output register, frees the sequencer while the result waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == qsv_pkg::S_DONE && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == qsv_pkg::S_DONE && slot_free) begin
      out_re_r <= rres_re_r;
      out_im_r <= rres_im_r;
      out_st_r <= status_r;
    end
  end

  assign out_if.valid  = out_valid_r;
  assign out_if.amp_re = out_re_r;
  assign out_if.amp_im = out_im_r;
  assign out_if.status = out_st_r;

  qsv_mem #(
    .AW (AW),
    .DW (DW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  qsv_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .x   (mac_x),
    .y   (mac_y),
    .res (mac_res)
  );

  // ---- checks
  `QSV_ASSERT_NXT(a_accept_busy, accept, state_r != qsv_pkg::S_IDLE, "transaction accepted but sequencer stayed idle")
  `QSV_ASSERT_IMP(a_we_busy, mem_we, state_r != qsv_pkg::S_IDLE && state_r != qsv_pkg::S_DONE, "memory written outside a transaction")
  `QSV_ASSERT_IMP(a_err_zero, out_valid_r && out_st_r != qsv_pkg::ST_OK, out_re_r == '0 && out_im_r == '0, "error result carries nonzero amplitude")
  `QSV_ASSERT_IMP(a_step_range, state_r == qsv_pkg::S_PMUL, step_r <= 3'd4, "multiplier step out of range")

endmodule
